// ===== design/sai_pkg.sv =====
// Shared types, mode codes and saturating arithmetic for the interval overlap unit.
package sai_pkg;

  typedef logic signed [47:0] val_t;

  localparam val_t VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam val_t VAL_MIN = 48'sh8000_0000_0000;

  localparam logic [3:0] MODE_AXIS   = 4'd0;
  localparam logic [3:0] MODE_OFFSET = 4'd1;
  localparam logic [3:0] MODE_POINT  = 4'd2;
  localparam logic [3:0] MODE_BOXMIN = 4'd3;
  localparam logic [3:0] MODE_BOXMAX = 4'd4;
  localparam logic [3:0] MODE_CENTER = 4'd5;
  localparam logic [3:0] MODE_HALF   = 4'd6;
  localparam logic [3:0] MODE_ROT0   = 4'd7;
  localparam logic [3:0] MODE_ROT1   = 4'd8;
  localparam logic [3:0] MODE_ROT2   = 4'd9;

  // Interval tracker controls
  typedef struct packed {
    logic widen;
    logic emit;
    logic side;
  } ivl_ctl_t;

  function automatic val_t sext32(logic [31:0] v);
    sext32 = {{16{v[31]}}, v};
  endfunction

  // a + b or a - b, saturated to 48 bits
  function automatic val_t sat_add(val_t a, val_t b, logic sub);
    logic [48:0] s;
    if (sub) begin
      s = {a[47], a} - {b[47], b};
    end else begin
      s = {a[47], a} + {b[47], b};
    end
    if (s[48] != s[47]) begin
      sat_add = s[48] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_add = s[47:0];
    end
  endfunction

endpackage

// ===== design/sai_mulq.sv =====
// Shared Q16.16 multiplier: 48x32 product in two 25x32 passes, floor >> 16, saturate to 48.
module sai_mulq
  import sai_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  val_t        c_i,
  input  logic [31:0] a_i,
  output logic        done_o,
  output val_t        res_o
);

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SAT} mstate_e;

  mstate_e            state_q;
  logic               done_q;
  val_t               c_q;
  logic signed [31:0] a_q;
  logic signed [79:0] acc_q;
  val_t               res_q;

  logic signed [24:0] mcand;
  logic signed [56:0] prod;
  logic signed [79:0] prod_ext;
  logic               ovf;

  // low pass uses the unsigned bottom 24 bits, high pass the signed top 24 bits
  assign mcand    = (state_q == M_LO) ? $signed({1'b0, c_q[23:0]})
                                      : $signed({c_q[47], c_q[47:24]});
  assign prod     = mcand * a_q;
  assign prod_ext = {{23{prod[56]}}, prod};
  assign ovf      = !((&acc_q[79:63]) || !(|acc_q[79:63]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) state_q <= M_LO;
        end
        M_LO:  state_q <= M_HI;
        M_HI:  state_q <= M_SAT;
        M_SAT: begin
          state_q <= M_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          c_q <= c_i;
          a_q <= a_i;
        end
      end
      M_LO: acc_q <= prod_ext;
      M_HI: acc_q <= acc_q + (prod_ext <<< 24);
      M_SAT: begin
        if (ovf) begin
          res_q <= acc_q[79] ? VAL_MIN : VAL_MAX;
        end else begin
          res_q <= acc_q[63:16];
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/sai_interval.sv =====
// Per-side projection intervals, overlap check and registered result.
module sai_interval
  import sai_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ivl_ctl_t ctl_i,
  input  val_t     value_i,
  output logic     valid_o,
  output logic     overlap_o,
  output val_t     first_low_o,
  output val_t     first_high_o,
  output val_t     second_low_o,
  output val_t     second_high_o
);

  logic [1:0] seen_q;
  logic       valid_q;
  val_t       low_q  [2];
  val_t       high_q [2];
  logic       ovl_q;
  val_t       f_lo_q, f_hi_q, s_lo_q, s_hi_q;

  logic both;
  logic ovl;

  assign both = seen_q[0] && seen_q[1];
  assign ovl  = both && (high_q[0] >= low_q[1]) && (high_q[1] >= low_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.emit;
      if (ctl_i.emit) begin
        seen_q <= '0;
      end else if (ctl_i.widen) begin
        seen_q[ctl_i.side] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.widen) begin
      if (!seen_q[ctl_i.side]) begin
        low_q[ctl_i.side]  <= value_i;
        high_q[ctl_i.side] <= value_i;
      end else begin
        if (value_i < low_q[ctl_i.side])  low_q[ctl_i.side]  <= value_i;
        if (value_i > high_q[ctl_i.side]) high_q[ctl_i.side] <= value_i;
      end
    end
    if (ctl_i.emit) begin
      ovl_q  <= ovl;
      f_lo_q <= both ? low_q[0]  : '0;
      f_hi_q <= both ? high_q[0] : '0;
      s_lo_q <= both ? low_q[1]  : '0;
      s_hi_q <= both ? high_q[1] : '0;
    end
  end

  assign valid_o       = valid_q;
  assign overlap_o     = ovl_q;
  assign first_low_o   = f_lo_q;
  assign first_high_o  = f_hi_q;
  assign second_low_o  = s_lo_q;
  assign second_high_o = s_hi_q;

endmodule

// ===== design/sat_axis_interval_overlap_unit.sv =====
// Top level: item sequencer, shape storage and vertex datapath around one shared multiplier.
//
// One item is taken when start is high and busy is low; busy stays high until the item is
// done. Storing items (axis, translation, box min, center, half size, rotation rows, unused
// modes) go straight to the finish state. A triangle point, a completed axis-aligned box and
// a completed oriented box are paced by the one shared multiplier, which finishes each Q16.16
// product before it takes the next: three per projected vertex, plus nine rotation-by-half-size
// products for an oriented box. For an item with last set, done_o pulses for one cycle, as
// busy falls, with the overlap flag and the four bounds; the receiver cannot stall, so done_o
// marks the result only in that cycle, and the flag and bounds hold until the next such item.
module sat_axis_interval_overlap_unit
  import sai_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         mode_i,
  input  logic               side_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic               last_i,
  output logic               done_o,
  output logic               overlap_o,
  output val_t               first_low_o,
  output val_t               first_high_o,
  output val_t               second_low_o,
  output val_t               second_high_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP_A, ST_PREP_O, ST_CORNER, ST_TMUL, ST_TWAIT,
    ST_VERT, ST_PMUL, ST_PWAIT, ST_WIDEN, ST_FIN
  } state_e;

  state_e      state_q;
  logic [3:0]  mode_q;
  logic        side_q;
  logic        last_q;
  logic [2:0]  k_q;
  logic [1:0]  i_q;
  logic [1:0]  j_q;

  logic [31:0] axis_q [3];
  logic [31:0] offs_q [3];
  logic [31:0] anch_q [3];
  logic [31:0] half_q [3];
  logic [31:0] rot_q  [6];

  logic [31:0] vec_q  [3];
  val_t        base_q [3];
  val_t        aux_q  [9];
  val_t        pnt_q  [3];
  val_t        prj_q;

  logic [31:0] vin [3];
  logic        accept;
  logic        mul_start;
  logic        mul_done;
  val_t        mul_c;
  val_t        mul_res;
  logic [31:0] mul_a;
  logic [31:0] row;
  logic [1:0]  jm1;
  ivl_ctl_t    ivl_ctl;

  // product table slot for row j, component i
  function automatic logic [3:0] tidx(logic [1:0] j, logic [1:0] i);
    tidx = 4'({2'b00, j} * 4'd3) + {2'b00, i};
  endfunction

  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);
  assign jm1    = j_q - 2'd1;

  // Shape and axis storage, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 3; n++) begin
        axis_q[n] <= '0;
        offs_q[n] <= '0;
        anch_q[n] <= '0;
        half_q[n] <= '0;
      end
      for (int n = 0; n < 6; n++) rot_q[n] <= '0;
    end else if (accept) begin
      case (mode_i)
        MODE_AXIS:   for (int n = 0; n < 3; n++) axis_q[n] <= vin[n];
        MODE_OFFSET: for (int n = 0; n < 3; n++) offs_q[n] <= vin[n];
        MODE_BOXMIN: for (int n = 0; n < 3; n++) anch_q[n] <= vin[n];
        MODE_CENTER: for (int n = 0; n < 3; n++) anch_q[n] <= vin[n];
        MODE_HALF:   for (int n = 0; n < 3; n++) half_q[n] <= vin[n];
        MODE_ROT0:   for (int n = 0; n < 3; n++) rot_q[n] <= vin[n];
        MODE_ROT1:   for (int n = 0; n < 3; n++) rot_q[n + 3] <= vin[n];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_AXIS;
      side_q  <= 1'b0;
      last_q  <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            mode_q <= mode_i;
            side_q <= side_i;
            last_q <= last_i;
            k_q    <= '0;
            i_q    <= '0;
            j_q    <= '0;
            case (mode_i)
              MODE_POINT:  state_q <= ST_PMUL;
              MODE_BOXMAX: state_q <= ST_PREP_A;
              MODE_ROT2:   state_q <= ST_PREP_O;
              default:     state_q <= ST_FIN;
            endcase
          end
        end
        ST_PREP_A: state_q <= ST_CORNER;
        ST_PREP_O: state_q <= ST_TMUL;
        ST_CORNER: state_q <= ST_PMUL;
        ST_TMUL:   state_q <= ST_TWAIT;
        ST_TWAIT: begin
          if (mul_done) begin
            if (i_q == 2'd2) begin
              i_q <= '0;
              if (j_q == 2'd2) begin
                j_q     <= '0;
                state_q <= ST_VERT;
              end else begin
                j_q     <= j_q + 2'd1;
                state_q <= ST_TMUL;
              end
            end else begin
              i_q     <= i_q + 2'd1;
              state_q <= ST_TMUL;
            end
          end
        end
        ST_VERT: begin
          // per component: load translated center, then add or subtract three products
          if (j_q == 2'd3) begin
            j_q <= '0;
            if (i_q == 2'd2) begin
              i_q     <= '0;
              state_q <= ST_PMUL;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        ST_PMUL: state_q <= ST_PWAIT;
        ST_PWAIT: begin
          if (mul_done) begin
            if (i_q == 2'd2) begin
              i_q     <= '0;
              state_q <= ST_WIDEN;
            end else begin
              i_q     <= i_q + 2'd1;
              state_q <= ST_PMUL;
            end
          end
        end
        ST_WIDEN: begin
          if ((mode_q != MODE_POINT) && (k_q != 3'd7)) begin
            k_q     <= k_q + 3'd1;
            state_q <= (mode_q == MODE_BOXMAX) ? ST_CORNER : ST_VERT;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN:  state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Vertex datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int n = 0; n < 3; n++) vec_q[n] <= vin[n];
      if (mode_i == MODE_POINT) begin
        for (int n = 0; n < 3; n++) pnt_q[n] <= sext32(vin[n]);
      end
    end
    case (state_q)
      ST_PREP_A: begin
        for (int n = 0; n < 3; n++) begin
          base_q[n] <= sat_add(sext32(anch_q[n]), sext32(offs_q[n]), 1'b0);
          aux_q[n]  <= sat_add(sext32(vec_q[n]), sext32(offs_q[n]), 1'b0);
        end
      end
      ST_PREP_O: begin
        for (int n = 0; n < 3; n++) begin
          base_q[n] <= sat_add(sext32(anch_q[n]), sext32(offs_q[n]), 1'b0);
        end
      end
      ST_CORNER: begin
        // bit n of the corner index picks max or min per component
        for (int n = 0; n < 3; n++) pnt_q[n] <= k_q[n] ? aux_q[n] : base_q[n];
      end
      ST_TWAIT: begin
        if (mul_done) aux_q[tidx(j_q, i_q)] <= mul_res;
      end
      ST_VERT: begin
        if (j_q == 2'd0) begin
          pnt_q[i_q] <= base_q[i_q];
        end else begin
          pnt_q[i_q] <= sat_add(pnt_q[i_q], aux_q[tidx(jm1, i_q)], k_q[jm1]);
        end
      end
      ST_PWAIT: begin
        if (mul_done) begin
          prj_q <= (i_q == 2'd0) ? mul_res : sat_add(prj_q, mul_res, 1'b0);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (j_q)
      2'd0:    row = rot_q[{1'b0, i_q}];
      2'd1:    row = rot_q[{1'b0, i_q} + 3'd3];
      default: row = vec_q[i_q];
    endcase
    if (state_q == ST_TMUL) begin
      mul_c = sext32(row);
      mul_a = half_q[j_q];
    end else begin
      mul_c = pnt_q[i_q];
      mul_a = axis_q[i_q];
    end
  end

  assign mul_start     = (state_q == ST_TMUL) || (state_q == ST_PMUL);
  assign ivl_ctl.widen = (state_q == ST_WIDEN);
  assign ivl_ctl.emit  = (state_q == ST_FIN) && last_q;
  assign ivl_ctl.side  = side_q;

  sai_mulq u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .c_i     (mul_c),
    .a_i     (mul_a),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  sai_interval u_interval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ivl_ctl),
    .value_i       (prj_q),
    .valid_o       (done_o),
    .overlap_o     (overlap_o),
    .first_low_o   (first_low_o),
    .first_high_o  (first_high_o),
    .second_low_o  (second_low_o),
    .second_high_o (second_high_o)
  );

endmodule
